>>> hdl/cdq_pkg.sv
// Shared types and codes for the circular deque.
package cdq_pkg;

  typedef logic [2:0]        action_t;
  typedef logic [1:0]        status_t;
  typedef logic [4:0]        count_t;
  typedef logic signed [31:0] data_t;

  // Action codes
  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_REAR  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_REAR   = 3'd3;
  localparam action_t ACT_LIST       = 3'd4;

  // Status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

  // One result item
  typedef struct packed {
    status_t status;
    data_t   item_value;
    data_t   front_value;
    data_t   rear_value;
    count_t  occupancy;
    logic    is_full;
    logic    is_empty;
    logic    last;
  } result_t;

endpackage

>>> hdl/cdq_if.sv
// Valid/ready channel interfaces for commands and results.
interface cdq_in_if import cdq_pkg::*;;
  logic    valid;
  logic    ready;
  action_t action;
  data_t   push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink (input valid, input action, input push_value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*;;
  logic    valid;
  logic    ready;
  status_t status;
  data_t   item_value;
  data_t   front_value;
  data_t   rear_value;
  count_t  occupancy;
  logic    is_full;
  logic    is_empty;
  logic    last;

  modport source (output valid, output status, output item_value, output front_value,
                  output rear_value, output occupancy, output is_full, output is_empty,
                  output last, input ready);
  modport sink (input valid, input status, input item_value, input front_value,
                input rear_value, input occupancy, input is_full, input is_empty,
                input last, output ready);
endinterface

>>> hdl/cdq_ram.sv
// Slot memory: one write port, one read port with registered read data.
module cdq_ram import cdq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  data_t         wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output data_t         rd_data
);

  data_t mem [DEPTH];

  // Write slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read slot; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/cdq_ctrl.sv
// Deque sequencer: pointers, count, cached end values and the list walk.
module cdq_ctrl import cdq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  action_t       in_action,
  input  data_t         in_push_value,
  input  logic          out_free,
  output logic          res_load,
  output result_t       res,
  input  logic          cfg_write_en,
  input  count_t        cfg_write_data,
  output logic          wr_en,
  output logic [IW-1:0] wr_addr,
  output data_t         wr_data,
  output logic          rd_en,
  output logic [IW-1:0] rd_addr,
  input  data_t         rd_data
);

  localparam int CMPW      = (IW + 1 > 5) ? IW + 1 : 5;
  localparam int CAP_RESET = (DEPTH < 16) ? DEPTH : 16;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  logic [1:0]    state, state_next;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [IW-1:0] walk, walk_next;
  count_t        count, count_next;
  count_t        cap, cap_next;
  count_t        remain, remain_next;
  data_t         front_val, front_next;
  data_t         rear_val, rear_next;
  logic          pop_front, pop_front_next;
  logic          accept;
  status_t       res_status;
  data_t         res_item;
  logic          res_last;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i, input count_t c);
    logic [CMPW-1:0] inc;
    inc = CMPW'(i) + CMPW'(1);
    return (inc >= CMPW'(c)) ? '0 : IW'(inc);
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i, input count_t c);
    count_t top;
    top = c - 5'd1;
    return (i == '0) ? IW'(top) : i - IW'(1);
  endfunction

  function automatic count_t sat_cap(input count_t v);
    count_t r;
    r = v;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (CMPW'(v) > CMPW'(DEPTH)) begin
      r = 5'(DEPTH);
    end
    return r;
  endfunction

  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Sequence actions
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    walk_next      = walk;
    count_next     = count;
    cap_next       = cap;
    remain_next    = remain;
    front_next     = front_val;
    rear_next      = rear_val;
    pop_front_next = pop_front;
    res_load       = 1'b0;
    res_status     = ST_OK;
    res_item       = '0;
    res_last       = 1'b1;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = in_push_value;
    rd_en          = 1'b0;
    rd_addr        = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
              res_load = 1'b1;
              if (count >= cap) begin
                res_status = ST_OVERFLOW;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 5'd1;
                if (count == 5'd0) begin
                  head_next  = '0;
                  tail_next  = '0;
                  wr_addr    = '0;
                  front_next = in_push_value;
                  rear_next  = in_push_value;
                end else if (in_action == ACT_PUSH_FRONT) begin
                  head_next  = ring_prev(head, cap);
                  wr_addr    = head_next;
                  front_next = in_push_value;
                end else begin
                  tail_next = ring_next(tail, cap);
                  wr_addr   = tail_next;
                  rear_next = in_push_value;
                end
              end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
              if (count == 5'd0) begin
                res_load   = 1'b1;
                res_status = ST_UNDERFLOW;
              end else if (count == 5'd1) begin
                res_load   = 1'b1;
                count_next = 5'd0;
              end else begin
                // Move the pointer and fetch the new end element
                count_next     = count - 5'd1;
                rd_en          = 1'b1;
                pop_front_next = (in_action == ACT_POP_FRONT);
                state_next     = S_POP;
                if (in_action == ACT_POP_FRONT) begin
                  head_next = ring_next(head, cap);
                  rd_addr   = head_next;
                end else begin
                  tail_next = ring_prev(tail, cap);
                  rd_addr   = tail_next;
                end
              end
            end
            ACT_LIST: begin
              if (count == 5'd0) begin
                res_load   = 1'b1;
                res_status = ST_UNDERFLOW;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = head;
                walk_next   = head;
                remain_next = count;
                state_next  = S_LIST;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end else if (cfg_write_en && count == 5'd0) begin
          cap_next  = sat_cap(cfg_write_data);
          head_next = '0;
          tail_next = '0;
        end
      end
      S_POP: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (pop_front) begin
            front_next = rd_data;
          end else begin
            rear_next = rd_data;
          end
        end
      end
      S_LIST: begin
        if (out_free) begin
          res_load = 1'b1;
          res_item = rd_data;
          res_last = (remain == 5'd1);
          if (remain == 5'd1) begin
            state_next = S_IDLE;
          end else begin
            walk_next   = ring_next(walk, cap);
            remain_next = remain - 5'd1;
            rd_en       = 1'b1;
            rd_addr     = walk_next;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Build the result from the state after the action
  always_comb begin
    res.status      = res_status;
    res.item_value  = res_item;
    res.front_value = (count_next == 5'd0) ? '0 : front_next;
    res.rear_value  = (count_next == 5'd0) ? '0 : rear_next;
    res.occupancy   = count_next;
    res.is_full     = (count_next == cap_next);
    res.is_empty    = (count_next == 5'd0);
    res.last        = res_last;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      cap   <= 5'(CAP_RESET);
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      cap   <= cap_next;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk) begin
    walk      <= walk_next;
    remain    <= remain_next;
    front_val <= front_next;
    rear_val  <= rear_next;
    pop_front <= pop_front_next;
  end

  a_count_in_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap)
    else $error("held count above capacity");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded into a busy output register");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |-> (remain != 5'd0 && count != 5'd0))
    else $error("list walk with nothing left");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.last) |=> (state == S_IDLE))
    else $error("sequencer busy after final result");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !wr_en)
    else $error("slot write during a fetch");

endmodule

>>> hdl/circular_deque_top.sv
// Circular deque
//
// Channels: cmd (sink) takes an action and a push value; rsp (source) gives
// status, listed item, front and rear values, occupancy, full/empty flags and
// a last mark. A transfer happens at a rising edge with valid and ready high.
// cfg_write_en/cfg_write_data set the capacity, taken only while empty and
// saturated into 1..DEPTH; it also rewinds both ring pointers.
//
// Timing: push, failed actions and undefined actions give their result in the
// cycle after the command transfer. A pop that leaves elements re-reads the
// new end element from the slot memory, so its result passes the registered
// read data and then the result register; a list gives its first element the
// same way, then one element per cycle while the receiver keeps ready high.
// One command is in work at a time.
//
// Reset (rst, synchronous) empties the deque and sets capacity to 16, or to
// DEPTH if smaller. When the receiver stalls, the result register holds and
// no new command is taken until the result has been transferred.
module circular_deque_top import cdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  cdq_in_if.sink        cmd,
  cdq_out_if.source     rsp,
  input  logic          cfg_write_en,
  input  count_t        cfg_write_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          out_valid;
  logic          out_free;
  logic          res_load;
  result_t       res;
  result_t       out_reg;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  data_t         wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  data_t         rd_data;

  assign out_free = !out_valid || rsp.ready;

  cdq_ctrl #(.DEPTH(DEPTH), .IW(IW)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (cmd.valid),
    .in_ready       (cmd.ready),
    .in_action      (cmd.action),
    .in_push_value  (cmd.push_value),
    .out_free       (out_free),
    .res_load       (res_load),
    .res            (res),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  cdq_ram #(.DEPTH(DEPTH), .IW(IW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold the result until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_reg <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_reg.status;
  assign rsp.item_value  = out_reg.item_value;
  assign rsp.front_value = out_reg.front_value;
  assign rsp.rear_value  = out_reg.rear_value;
  assign rsp.occupancy   = out_reg.occupancy;
  assign rsp.is_full     = out_reg.is_full;
  assign rsp.is_empty    = out_reg.is_empty;
  assign rsp.last        = out_reg.last;

endmodule

>>> sim/circular_deque_checker.sv
// Checker for the circular deque: predicts every result and compares the transfers.
module circular_deque_checker import cdq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  cdq_in_if           cmd,
  cdq_out_if          rsp,
  input  logic        cfg_write_en,
  input  count_t      cfg_write_data,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam count_t RESET_CAP = (DEPTH < 16) ? count_t'(DEPTH) : count_t'(16);

  // Mirror of the deque state
  data_t      slot_mem [DEPTH];
  logic [3:0] head_ptr;
  logic [3:0] tail_ptr;
  count_t     held;
  count_t     cap;

  // Results still owed by the block, oldest first
  result_t    owed_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [3:0] ring_fwd(logic [3:0] i);
    return ({1'b0, i} + 5'd1 >= cap) ? 4'd0 : i + 4'd1;
  endfunction

  function automatic logic [3:0] ring_back(logic [3:0] i);
    return (i == 4'd0) ? 4'(cap - 5'd1) : i - 4'd1;
  endfunction

  // Build one result from the state as it stands now
  function automatic result_t snapshot(status_t st, data_t item, logic fin);
    result_t r;
    r.status      = st;
    r.item_value  = item;
    r.front_value = (held == 0) ? data_t'(0) : slot_mem[head_ptr];
    r.rear_value  = (held == 0) ? data_t'(0) : slot_mem[tail_ptr];
    r.occupancy   = held;
    r.is_full     = (held == cap);
    r.is_empty    = (held == 0);
    r.last        = fin;
    return r;
  endfunction

  // Apply one command to the mirror and queue the results it causes
  task automatic predict_deque(action_t act, data_t val);
    logic [3:0] idx;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (held >= cap) begin
          owed_results.push_back(snapshot(ST_OVERFLOW, '0, 1'b1));
        end else begin
          if (held == 0) begin
            head_ptr    = '0;
            tail_ptr    = '0;
            slot_mem[0] = val;
          end else if (act == ACT_PUSH_FRONT) begin
            head_ptr           = ring_back(head_ptr);
            slot_mem[head_ptr] = val;
          end else begin
            tail_ptr           = ring_fwd(tail_ptr);
            slot_mem[tail_ptr] = val;
          end
          held++;
          owed_results.push_back(snapshot(ST_OK, '0, 1'b1));
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (held == 0) begin
          owed_results.push_back(snapshot(ST_UNDERFLOW, '0, 1'b1));
        end else begin
          if (held > 1) begin
            if (act == ACT_POP_FRONT) head_ptr = ring_fwd(head_ptr);
            else tail_ptr = ring_back(tail_ptr);
          end
          held--;
          owed_results.push_back(snapshot(ST_OK, '0, 1'b1));
        end
      end
      ACT_LIST: begin
        if (held == 0) begin
          owed_results.push_back(snapshot(ST_UNDERFLOW, '0, 1'b1));
        end else begin
          idx = head_ptr;
          for (int k = 0; k < held; k++) begin
            owed_results.push_back(snapshot(ST_OK, slot_mem[idx], k == held - 1));
            idx = ring_fwd(idx);
          end
        end
      end
      // Undefined actions leave the deque alone
      default: owed_results.push_back(snapshot(ST_OK, '0, 1'b1));
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got)
      report_mismatch($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    result_t want;
    count_t  sat;
    if (rst) begin
      head_ptr = '0;
      tail_ptr = '0;
      held     = '0;
      cap      = RESET_CAP;
      foreach (slot_mem[i]) slot_mem[i] = '0;
      owed_results.delete();
    end else begin
      // Take a capacity write only while empty, saturated into 1..DEPTH
      if (cfg_write_en && held == 0) begin
        sat = cfg_write_data;
        if (sat < 5'd1) sat = 5'd1;
        if (sat > count_t'(DEPTH)) sat = count_t'(DEPTH);
        cap      = sat;
        head_ptr = '0;
        tail_ptr = '0;
      end

      // Compare each result transfer against the oldest owed result
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result transfer with no result owed");
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("item_value", want.item_value, rsp.item_value);
          check_field("front_value", want.front_value, rsp.front_value);
          check_field("rear_value", want.rear_value, rsp.rear_value);
          check_field("occupancy", want.occupancy, rsp.occupancy);
          check_field("is_full", want.is_full, rsp.is_full);
          check_field("is_empty", want.is_empty, rsp.is_empty);
          check_field("last", want.last, rsp.last);
        end
      end

      // Predict on every command transfer
      if (cmd.valid && cmd.ready) predict_deque(cmd.action, cmd.push_value);
    end
    pending = owed_results.size();
  end

endmodule

>>> sim/circular_deque_top_test.sv
// Testbench top for the circular deque: stimulus, idling, and the verdict.
module circular_deque_top_test import cdq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET  = 470;
  localparam action_t     ACT_UNDEF_LO = ACT_LIST + 3'd1;
  localparam action_t     ACT_UNDEF_HI = '1;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write_en;
  count_t      cfg_write_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_count = 0;
  int unsigned stall_left = 0;
  logic        quiet      = 1'b0;
  logic        last_empty = 1'b1;

  cdq_in_if  cmd ();
  cdq_out_if rsp ();

  circular_deque_top dut (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rsp            (rsp),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  circular_deque_checker chk (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rsp            (rsp),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Bias the action mix: 0 balanced, 1 filling, 2 draining
  function automatic action_t pick_action(int unsigned mode);
    int unsigned r      = $urandom_range(0, 99);
    int unsigned push_w = (mode == 1) ? 60 : (mode == 2) ? 20 : 40;
    int unsigned pop_w  = (mode == 2) ? 60 : (mode == 1) ? 25 : 40;
    if (r < push_w) return $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
    if (r < push_w + pop_w) return $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
    if (r < 96) return ACT_LIST;
    return action_t'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
  endfunction

  function automatic count_t pick_capacity();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd2;
      3: return 5'd16;
      4: return 5'd31;
      default: return count_t'($urandom_range(1, 16));
    endcase
  endfunction

  // Stall the result channel at random
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp.ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 2) == 0) begin
      stall_left <= idle_len();
      rsp.ready  <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Track the empty flag of the latest result, used to drain between phases
  always @(posedge clk) begin
    if (rsp.valid && rsp.ready) last_empty <= rsp.is_empty;
  end

  // Offer one command, hold it until the transfer, then maybe idle
  task automatic send_cmd(action_t act, data_t val);
    int unsigned gap;
    cmd.valid      <= 1'b1;
    cmd.action     <= act;
    cmd.push_value <= val;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sent_count++;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every owed result has been transferred
  task automatic wait_drained();
    cmd.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_capacity(count_t c);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= c;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Pop until the deque reports empty
  task automatic drain_deque();
    for (int n = 0; n < 20 && !last_empty; n++) begin
      send_cmd($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR, pick_value());
      wait_drained();
    end
  endtask

  initial begin
    int unsigned phase_num;
    int unsigned mode;
    logic        paced;
    cmd.valid      = 1'b0;
    cmd.action     = ACT_PUSH_FRONT;
    cmd.push_value = '0;
    rsp.ready      = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    rst            = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Underflow on an empty deque
    send_cmd(ACT_POP_FRONT, pick_value());
    send_cmd(ACT_POP_REAR, pick_value());
    send_cmd(ACT_LIST, pick_value());
    // Extremes at both ends, then a full listing
    send_cmd(ACT_PUSH_FRONT, 32'h7fff_ffff);
    send_cmd(ACT_PUSH_REAR, 32'h8000_0000);
    send_cmd(ACT_PUSH_FRONT, '1);
    send_cmd(ACT_PUSH_REAR, '0);
    send_cmd(ACT_LIST, '0);
    // Undefined actions change nothing
    for (int a = ACT_UNDEF_LO; a <= ACT_UNDEF_HI; a++) send_cmd(action_t'(a), pick_value());
    send_cmd(ACT_POP_FRONT, '0);
    send_cmd(ACT_POP_REAR, '0);
    send_cmd(ACT_POP_FRONT, '0);
    send_cmd(ACT_LIST, '0);
    send_cmd(ACT_POP_REAR, '0);
    send_cmd(ACT_POP_REAR, '0);
    // Capacity write while holding an element is ignored
    send_cmd(ACT_PUSH_REAR, 32'h1234_5678);
    write_capacity(5'd3);
    send_cmd(ACT_POP_FRONT, '0);
    // Capacity zero saturates to one: overflow on both ends
    write_capacity(5'd0);
    send_cmd(ACT_PUSH_REAR, 32'h5a5a_a5a5);
    send_cmd(ACT_PUSH_FRONT, 32'h0f0f_f0f0);
    send_cmd(ACT_PUSH_REAR, 32'hf0f0_0f0f);
    send_cmd(ACT_LIST, '0);
    send_cmd(ACT_POP_FRONT, '0);
    // Oversized capacity saturates to the full depth
    write_capacity(5'd31);

    // Random phases, each with a new capacity write (taken only if empty) and its own pacing
    phase_num = 0;
    while (sent_count < ITEM_TARGET) begin
      wait_drained();
      if ($urandom_range(0, 3) != 0) drain_deque();
      write_capacity(pick_capacity());
      quiet = (phase_num % 5 == 2);
      paced = (phase_num % 7 == 3);
      mode  = $urandom_range(0, 2);
      repeat ($urandom_range(15, 45)) begin
        send_cmd(pick_action(mode), pick_value());
        if (paced) wait_drained();
      end
      phase_num++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
